// ===== rtl/rbst_pkg.sv =====
// Package for the ray versus box slab test.
// Holds the fixed field widths shared by the lanes and the top level. No dependencies.
package rbst_pkg;
    localparam int DIR_WIDTH  = 18;
    localparam int FAR_WIDTH  = 16;
    localparam int FRAC_BITS  = 16;
    localparam int EXT_WIDTH  = DIR_WIDTH + FAR_WIDTH;
    localparam int DEN_WIDTH  = EXT_WIDTH;
    localparam logic [FAR_WIDTH-1:0] FAR_RESET = 16'd100;
endpackage

// ===== rtl/ray_box_slab_test.sv =====
// Ray segment versus axis-aligned box test, three axis lanes and a merge stage.
// One request is accepted every cycle while no finished result is stalled at the output.
// Each lane holds two pipelined dividers, one quotient bit a stage.
// The whole pipeline holds while a finished result waits at the output.
// Synchronous active-low reset clears valid flags and sets far_distance to 100.
module ray_box_slab_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rbst_pkg::FAR_WIDTH-1:0]  i_far_distance,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_z,
    input  logic signed [rbst_pkg::DIR_WIDTH-1:0] i_dir_x,
    input  logic signed [rbst_pkg::DIR_WIDTH-1:0] i_dir_y,
    input  logic signed [rbst_pkg::DIR_WIDTH-1:0] i_dir_z,
    input  logic signed [COORD_WIDTH-1:0]   i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0]   i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0]   i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0]   i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0]   i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0]   i_box_max_z,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit
);
    import rbst_pkg::*;

    localparam int NW  = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int LAT = NW + 4;
    localparam int IW  = COORD_WIDTH + 2;

    logic [FAR_WIDTH-1:0] r_far;
    logic [LAT-1:0]       r_vld;
    logic                 adv;
    logic signed [COORD_WIDTH-1:0] t_lo [0:2];
    logic signed [COORD_WIDTH-1:0] t_hi [0:2];
    logic                 par [0:2];
    logic                 ppass [0:2];
    logic                 n_hit;

    assign adv         = !o_valid || i_ready;
    assign o_ready     = adv;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far <= FAR_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) r_far <= i_far_distance;
            if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    rbst_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk(i_clk), .i_en(adv), .i_far(r_far), .i_org(i_origin_x), .i_dir(i_dir_x),
        .i_lo(i_box_min_x), .i_hi(i_box_max_x), .o_t_lo(t_lo[0]), .o_t_hi(t_hi[0]),
        .o_par(par[0]), .o_ppass(ppass[0])
    );
    rbst_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk(i_clk), .i_en(adv), .i_far(r_far), .i_org(i_origin_y), .i_dir(i_dir_y),
        .i_lo(i_box_min_y), .i_hi(i_box_max_y), .o_t_lo(t_lo[1]), .o_t_hi(t_hi[1]),
        .o_par(par[1]), .o_ppass(ppass[1])
    );
    rbst_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .i_clk(i_clk), .i_en(adv), .i_far(r_far), .i_org(i_origin_z), .i_dir(i_dir_z),
        .i_lo(i_box_min_z), .i_hi(i_box_max_z), .o_t_lo(t_lo[2]), .o_t_hi(t_hi[2]),
        .o_par(par[2]), .o_ppass(ppass[2])
    );

    always_comb begin
        logic signed [IW-1:0] enter, exitv, lo, hi;
        enter = '0;
        exitv = IW'(1 << FRAC_BITS);
        n_hit = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo = IW'(t_lo[a]);
            hi = IW'(t_hi[a]);
            if (n_hit) begin
                if (par[a]) begin
                    n_hit = ppass[a];
                end else if (enter > hi || lo > exitv) begin
                    n_hit = 1'b0;
                end else begin
                    if (lo > enter) enter = lo;
                    if (hi < exitv) exitv = hi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_hit <= n_hit;
    end
endmodule

// ===== rtl/rbst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on rbst_pkg for the divisor width.
module rbst_div #(
    parameter int NUM_WIDTH = 49
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NUM_WIDTH-1:0]          i_num,
    input  logic [rbst_pkg::DEN_WIDTH-1:0] i_den,
    output logic [NUM_WIDTH-1:0]          o_quo
);
    import rbst_pkg::*;

    logic [NUM_WIDTH-1:0] r_num [1:NUM_WIDTH-1];
    logic [NUM_WIDTH-1:0] r_quo [1:NUM_WIDTH];
    logic [DEN_WIDTH-1:0] r_rem [1:NUM_WIDTH-1];
    logic [DEN_WIDTH-1:0] r_den [1:NUM_WIDTH-1];

    for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_stage
        logic [NUM_WIDTH-1:0] num_in;
        logic [NUM_WIDTH-1:0] quo_in;
        logic [DEN_WIDTH-1:0] rem_in;
        logic [DEN_WIDTH-1:0] den_in;
        logic [DEN_WIDTH:0]   trial;
        logic                 take;

        if (k == 0) begin : g_first
            assign num_in = i_num;
            assign quo_in = '0;
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign num_in = r_num[k];
            assign quo_in = r_quo[k];
            assign rem_in = r_rem[k];
            assign den_in = r_den[k];
        end

        assign trial = {rem_in, num_in[NUM_WIDTH-1]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= {quo_in[NUM_WIDTH-2:0], take};
            end
        end

        if (k < NUM_WIDTH - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k+1] <= {num_in[NUM_WIDTH-2:0], 1'b0};
                    r_rem[k+1] <= take ? DEN_WIDTH'(trial - {1'b0, den_in})
                                       : trial[DEN_WIDTH-1:0];
                    r_den[k+1] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[NUM_WIDTH];
endmodule

// ===== rtl/rbst_lane.sv =====
// One axis lane: extent, the two slab parameters, saturation and ordering.
// Depends on rbst_pkg and rbst_div.
module rbst_lane #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rbst_pkg::FAR_WIDTH-1:0]  i_far,
    input  logic signed [COORD_WIDTH-1:0]   i_org,
    input  logic signed [rbst_pkg::DIR_WIDTH-1:0] i_dir,
    input  logic signed [COORD_WIDTH-1:0]   i_lo,
    input  logic signed [COORD_WIDTH-1:0]   i_hi,
    output logic signed [COORD_WIDTH-1:0]   o_t_lo,
    output logic signed [COORD_WIDTH-1:0]   o_t_hi,
    output logic                            o_par,
    output logic                            o_ppass
);
    import rbst_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int NW = DW + FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] LIM = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [DW-1:0]        r_da, r_db;
    logic signed [EXT_WIDTH-1:0] r_ext;
    logic                        r_pp_a;
    logic [NW-1:0]               r_na, r_nb;
    logic [DEN_WIDTH-1:0]        r_den;
    logic                        r_par [0:NW+1];
    logic                        r_pp  [0:NW+1];
    logic                        r_neg_a [0:NW];
    logic                        r_neg_b [0:NW];
    logic [NW-1:0]               qa, qb;
    logic signed [COORD_WIDTH-1:0] sa, sb;
    logic signed [DIR_WIDTH+FAR_WIDTH:0] prod;

    assign prod = i_dir * $signed({1'b0, i_far});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_da   <= DW'(i_lo) - DW'(i_org);
            r_db   <= DW'(i_hi) - DW'(i_org);
            r_ext  <= prod[EXT_WIDTH-1:0];
            r_pp_a <= !(i_org < i_lo || i_org > i_hi);
            r_na   <= {(r_da[DW-1] ? DW'(-r_da) : r_da), {FRAC_BITS{1'b0}}};
            r_nb   <= {(r_db[DW-1] ? DW'(-r_db) : r_db), {FRAC_BITS{1'b0}}};
            r_den  <= r_ext[EXT_WIDTH-1] ? DEN_WIDTH'(-r_ext) : DEN_WIDTH'(r_ext);
            r_par[0]   <= r_ext == '0;
            r_pp[0]    <= r_pp_a;
            r_neg_a[0] <= r_da[DW-1] != r_ext[EXT_WIDTH-1];
            r_neg_b[0] <= r_db[DW-1] != r_ext[EXT_WIDTH-1];
            for (int k = 0; k < NW; k++) begin
                r_neg_a[k+1] <= r_neg_a[k];
                r_neg_b[k+1] <= r_neg_b[k];
            end
            for (int k = 0; k < NW + 1; k++) begin
                r_par[k+1] <= r_par[k];
                r_pp[k+1]  <= r_pp[k];
            end
        end
    end

    rbst_div #(.NUM_WIDTH(NW)) u_div_a (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_na), .i_den(r_den), .o_quo(qa)
    );
    rbst_div #(.NUM_WIDTH(NW)) u_div_b (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_nb), .i_den(r_den), .o_quo(qb)
    );

    function automatic logic [COORD_WIDTH-1:0] sat(input logic [NW-1:0] q, input logic neg);
        logic over;
        over = |q[NW-1:COORD_WIDTH];
        if (neg) begin
            if (over || q[COORD_WIDTH-1:0] > LIM) return LIM;
            return COORD_WIDTH'(-q[COORD_WIDTH-1:0]);
        end
        if (over || q[COORD_WIDTH-1]) return LIM - 1'b1;
        return q[COORD_WIDTH-1:0];
    endfunction

    assign sa = $signed(sat(qa, r_neg_a[NW]));
    assign sb = $signed(sat(qb, r_neg_b[NW]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_t_lo <= (sa > sb) ? sb : sa;
            o_t_hi <= (sa > sb) ? sa : sb;
        end
    end

    assign o_par   = r_par[NW+1];
    assign o_ppass = r_pp[NW+1];
endmodule

// ===== rtl/rbst_checker.sv =====
// Port-level checker for ray_box_slab_test and its bind statement.
// Depends only on the top level's ports.
module rbst_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_hit,
    input logic o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit))
        else $error("Result changed while stalled.");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("Input stalled without a waiting result.");
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid)
        else $error("Result shown right after reset.");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("Configuration port not ready.");
endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit), .o_cfg_ready(o_cfg_ready)
);

// ===== test/ray_box_slab_test_tb.sv =====
// Testbench for ray_box_slab_test: directed table plus random segment/box requests.
// Predicts the hit flag with a local slab-test model; depends on rbst_pkg and the RTL.
module ray_box_slab_test_tb;
    import rbst_pkg::*;

    localparam int CW = 32;
    localparam int LATENCY = CW + 21;
    localparam logic NO_HIT = 1'b0;
    localparam logic HIT = 1'b1;
    localparam logic [1:0] CHECK_PRED = 2'd2;

    typedef struct {
        logic signed [CW-1:0]        org [3];
        logic signed [DIR_WIDTH-1:0] dir [3];
        logic signed [CW-1:0]        bmin [3];
        logic signed [CW-1:0]        bmax [3];
    } ray_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [FAR_WIDTH-1:0] i_far_distance = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CW-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [DIR_WIDTH-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [CW-1:0] i_box_min_x = '0, i_box_min_y = '0, i_box_min_z = '0;
    logic signed [CW-1:0] i_box_max_x = '0, i_box_max_y = '0, i_box_max_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_hit;

    logic [FAR_WIDTH-1:0] far_dist;
    logic hit_queue [$];
    ray_req_t dir_rows [$];
    logic [1:0] dir_want [$];
    int errors = 0;
    int stall_phase = 0;
    bit stall_on = 1'b1;

    ray_box_slab_test #(.COORD_WIDTH(CW)) uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint quotient_q16(longint num, longint den);
        bit neg;
        longint unsigned n, d, ip, rem, lim, m;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        ip = n / d;
        rem = n % d;
        lim = 64'd1 << (CW - 1);
        if (ip >= (64'd1 << (CW - FRAC_BITS))) m = lim;
        else m = (ip << FRAC_BITS) + (rem << FRAC_BITS) / d;
        if (neg) begin
            if (m > lim) m = lim;
            return -longint'(m);
        end
        if (m > lim - 1) m = lim - 1;
        return longint'(m);
    endfunction

    function automatic logic predict_hit(ray_req_t r, logic [FAR_WIDTH-1:0] fd);
        longint enter, leave, org, lo, hi, ext, ta, tb, t;
        enter = 0;
        leave = 64'sd1 << FRAC_BITS;
        for (int a = 0; a < 3; a++) begin
            org = r.org[a];
            lo = r.bmin[a];
            hi = r.bmax[a];
            ext = longint'(r.dir[a]) * longint'({1'b0, fd});
            if (ext == 0) begin
                if (org < lo || org > hi) return NO_HIT;
            end else begin
                ta = quotient_q16(lo - org, ext);
                tb = quotient_q16(hi - org, ext);
                if (ta > tb) begin
                    t = ta; ta = tb; tb = t;
                end
                if (enter > tb || ta > leave) return NO_HIT;
                if (ta > enter) enter = ta;
                if (tb < leave) leave = tb;
            end
        end
        return HIT;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic queue_hit(logic v);
        hit_queue = {hit_queue, v};
    endtask

    task automatic add_row(ray_req_t r, logic [1:0] w);
        dir_rows = {dir_rows, r};
        dir_want = {dir_want, w};
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_queue.size() == 0) report_mismatch("hit result with no request pending");
            else begin
                logic want;
                want = hit_queue.pop_front();
                if (o_hit !== want)
                    report_mismatch($sformatf("hit got %b want %b", o_hit, want));
            end
        end
        if (stall_phase == 0) begin
            stall_on <= !stall_on;
            stall_phase <= stall_on ? $urandom_range(1, 20) : $urandom_range(0, 4);
            i_ready <= stall_on ? 1'b1 : 1'b0;
        end else begin
            stall_phase <= stall_phase - 1;
        end
    end

    task automatic write_far(logic [FAR_WIDTH-1:0] v);
        i_far_distance <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        far_dist = v;
    endtask

    task automatic drain();
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_ray(ray_req_t r, logic [1:0] fixed_hit);
        i_origin_x <= r.org[0]; i_origin_y <= r.org[1]; i_origin_z <= r.org[2];
        i_dir_x <= r.dir[0]; i_dir_y <= r.dir[1]; i_dir_z <= r.dir[2];
        i_box_min_x <= r.bmin[0]; i_box_min_y <= r.bmin[1]; i_box_min_z <= r.bmin[2];
        i_box_max_x <= r.bmax[0]; i_box_max_y <= r.bmax[1]; i_box_max_z <= r.bmax[2];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        queue_hit(fixed_hit == CHECK_PRED ? predict_hit(r, far_dist) : fixed_hit[0]);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic signed [DIR_WIDTH-1:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIR_WIDTH'($urandom);
            2: return 18'sd65536;
            3: return -18'sd65536;
            default: return DIR_WIDTH'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic ray_req_t rand_ray();
        ray_req_t r;
        logic signed [CW-1:0] a, b;
        bit shaped;
        shaped = $urandom_range(0, 3) != 0;
        for (int k = 0; k < 3; k++) begin
            r.dir[k] = rand_dir();
            if (shaped) begin
                r.org[k] = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                a = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                b = a + $urandom_range(0, 32'h0080_0000);
                if ($urandom_range(0, 15) == 0) begin
                    r.bmin[k] = b; r.bmax[k] = a;
                end else begin
                    r.bmin[k] = a; r.bmax[k] = b;
                end
            end else begin
                r.org[k] = rand_coord();
                r.bmin[k] = rand_coord();
                r.bmax[k] = rand_coord();
            end
        end
        return r;
    endfunction

    function automatic ray_req_t mk(logic signed [CW-1:0] o, logic signed [DIR_WIDTH-1:0] d,
                                    logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
        ray_req_t r;
        for (int k = 0; k < 3; k++) begin
            r.org[k] = o; r.dir[k] = d; r.bmin[k] = lo; r.bmax[k] = hi;
        end
        return r;
    endfunction

    initial begin
        ray_req_t r;
        int burst;
        bit paused;
        paused = 1'b0;
        // Zero direction first: pure origin containment tests; then nonzero directions checked by the model.
        add_row(mk(0, 0, -65536, 65536), {1'b0, HIT});
        add_row(mk(0, 0, 65536, -65536), {1'b0, NO_HIT});
        add_row(mk(32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh7fff_ffff), {1'b0, HIT});
        add_row(mk(32'sh8000_0000, 0, 32'sh8000_0001, 32'sh7fff_ffff), {1'b0, NO_HIT});
        add_row(mk(0, 18'sd65536, 32'sh0010_0000, 32'sh0020_0000), CHECK_PRED);
        add_row(mk(0, -18'sd65536, -32'sh0020_0000, 32'sh0020_0000), CHECK_PRED);
        add_row(mk(32'sh8000_0000, 18'sh1ffff, 32'sh7fff_ffff, 32'sh8000_0000), CHECK_PRED);
        add_row(mk(32'sh7fff_ffff, 18'sh20000, 32'sh8000_0000, 32'sh7fff_ffff), CHECK_PRED);
        add_row(mk(0, 18'sd1, 32'sh0000_0001, 32'sh7fff_ffff), CHECK_PRED);
        add_row(mk(0, 18'sd65536, 32'sh0064_0000, 32'sh0065_0000), CHECK_PRED);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        far_dist = FAR_RESET;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_ray(dir_rows[i], dir_want[i]);
        i_valid <= 1'b0;
        drain();

        foreach (dir_rows[i]) begin
            if (i == 0) write_far(16'd0);
            send_ray(dir_rows[i], dir_want[i] == CHECK_PRED ? CHECK_PRED : dir_want[i]);
        end
        i_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_far(16'd1);
                1: write_far(16'hffff);
                2: write_far(16'd100);
                default: write_far(FAR_WIDTH'($urandom_range(1, 65535)));
            endcase
            for (int n = 0; n < 160; ) begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < 160; b++, n++) begin
                    r = rand_ray();
                    send_ray(r, CHECK_PRED);
                end
                if ($urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                if (n >= 80 && ph == 1 && !paused) begin
                    paused = 1'b1;
                    i_valid <= 1'b0;
                    while (hit_queue.size() != 0) @(posedge i_clk);
                end
            end
            i_valid <= 1'b0;
            drain();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rbst_pkg.sv
rtl/rbst_div.sv
rtl/rbst_lane.sv
rtl/ray_box_slab_test.sv
rtl/rbst_checker.sv
test/ray_box_slab_test_tb.sv
